[hdl/sha1md_pkg.sv]
package sha1md_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [7:0]  PAD_MARK = 8'h80;

  // Word index within a block after which the 64-bit length follows.
  localparam logic [3:0]  LEN_HI_IDX = 4'd13;
  localparam logic [3:0]  BLK_LAST_IDX = 4'd15;

  localparam logic [6:0]  RND_SCHED_START = 7'd16;
  localparam logic [6:0]  RND_PHASE1 = 7'd20;
  localparam logic [6:0]  RND_PHASE2 = 7'd40;
  localparam logic [6:0]  RND_PHASE3 = 7'd60;
  localparam logic [6:0]  RND_LAST = 7'd79;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [2:0]  DIGEST_LAST_IDX = 3'd4;

  typedef logic [31:0] word_t;

  // One message word on its way from the front to the compression engine.
  typedef struct packed {
    logic  msg_end;
    word_t data;
  } qword_t;

  // Push request from the front, with the queue's full flag beside it.
  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  function automatic word_t init_chain(input logic [2:0] idx);
    word_t v;
    v = 32'h0;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      3'd4:    v = 32'hC3D2E1F0;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic word_t rotl1(input word_t v);
    return {v[30:0], v[31]};
  endfunction

  function automatic word_t rotl5(input word_t v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic word_t rotl30(input word_t v);
    return {v[1:0], v[31:2]};
  endfunction

endpackage

[hdl/sha1md_if.sv]
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       final_item;

  modport source (output valid, data_byte, byte_present, final_item, input ready);
  modport sink   (input valid, data_byte, byte_present, final_item, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[hdl/sha1md_front.sv]
module sha1md_front
  import sha1md_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  sha1md_in_if.sink      in_ch,
  output qctl_t          qctl,
  input  logic           q_full,
  output qword_t         q_wdata
);

  localparam logic [2:0] F_BYTE = 3'd0;
  localparam logic [2:0] F_PADW = 3'd1;
  localparam logic [2:0] F_ZERO = 3'd2;
  localparam logic [2:0] F_LENH = 3'd3;
  localparam logic [2:0] F_LENL = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [63:0] len_r, len_nxt;
  logic [23:0] word_r, word_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        push;
  qword_t      wdata;
  word_t       pad_word;
  logic        in_fire;

  assign in_ch.ready = (state_r == F_BYTE) && !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The marker byte follows the bytes already packed into the open word.
  always_comb begin
    case (len_r[4:3])
      2'd0:    pad_word = {PAD_MARK, 24'h0};
      2'd1:    pad_word = {word_r[7:0], PAD_MARK, 16'h0};
      2'd2:    pad_word = {word_r[15:0], PAD_MARK, 8'h0};
      default: pad_word = {word_r[23:0], PAD_MARK};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    wdata     = '0;
    unique case (state_r)
      F_BYTE: begin
        if (in_fire) begin
          if (in_ch.byte_present) begin
            word_nxt = {word_r[15:0], in_ch.data_byte};
            len_nxt  = len_r + 64'd8;
            if (len_r[4:3] == 2'd3) begin
              push       = 1'b1;
              wdata.data = {word_r, in_ch.data_byte};
            end
          end
          if (in_ch.final_item) begin
            state_nxt = F_PADW;
          end
        end
      end
      F_PADW: begin
        if (!q_full) begin
          push       = 1'b1;
          wdata.data = pad_word;
          cnt_nxt    = len_r[8:5] + 4'd1;
          state_nxt  = (len_r[8:5] == LEN_HI_IDX) ? F_LENH : F_ZERO;
        end
      end
      F_ZERO: begin
        if (!q_full) begin
          push    = 1'b1;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == LEN_HI_IDX) begin
            state_nxt = F_LENH;
          end
        end
      end
      F_LENH: begin
        if (!q_full) begin
          push       = 1'b1;
          wdata.data = len_r[63:32];
          state_nxt  = F_LENL;
        end
      end
      F_LENL: begin
        if (!q_full) begin
          push          = 1'b1;
          wdata.data    = len_r[31:0];
          wdata.msg_end = 1'b1;
          len_nxt       = 64'd0;
          state_nxt     = F_BYTE;
        end
      end
      default: state_nxt = F_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_BYTE;
      len_r   <= 64'd0;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign qctl.push = push;
  assign qctl.full = q_full;
  assign q_wdata   = wdata;

endmodule

[hdl/sha1md_queue.sv]
module sha1md_queue
  import sha1md_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  qctl_t  qctl,
  input  qword_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   rvalid,
  output qword_t rdata
);

  qword_t         mem_r [QDepth];
  logic [QAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAw:0]   cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (QAw+1)'(QDepth));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = qctl.push && !qctl.full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hdl/sha1md_back.sv]
module sha1md_back
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  qword_t      q_rdata,
  output logic        q_pop,
  sha1md_out_if.source out_ch
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RND  = 2'd1;
  localparam logic [1:0] B_ADD  = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  word_t      chain_r [5];
  word_t      rr_r [5];
  word_t      win_r [16];
  logic [6:0] t_r;
  logic [2:0] idx_r;
  logic       last_blk_r;

  word_t      w, f, k, tmp;
  logic       rnd_go;

  // Rounds 0 to 15 take the word straight from the queue; later rounds expand.
  always_comb begin
    if (t_r < RND_SCHED_START) begin
      w = q_rdata.data;
    end else begin
      w = rotl1(win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0]);
    end
    if (t_r < RND_PHASE1) begin
      f = (rr_r[1] & rr_r[2]) | (~rr_r[1] & rr_r[3]);
      k = K0;
    end else if (t_r < RND_PHASE2) begin
      f = rr_r[1] ^ rr_r[2] ^ rr_r[3];
      k = K1;
    end else if (t_r < RND_PHASE3) begin
      f = (rr_r[1] & rr_r[2]) | (rr_r[1] & rr_r[3]) | (rr_r[2] & rr_r[3]);
      k = K2;
    end else begin
      f = rr_r[1] ^ rr_r[2] ^ rr_r[3];
      k = K3;
    end
    tmp = rotl5(rr_r[0]) + f + rr_r[4] + k + w;
  end

  assign rnd_go = (state_r == B_RND) && ((t_r >= RND_SCHED_START) || q_valid);
  assign q_pop  = rnd_go && (t_r < RND_SCHED_START);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (q_valid) state_nxt = B_RND;
      B_RND:  if (rnd_go && (t_r == RND_LAST)) state_nxt = B_ADD;
      B_ADD:  state_nxt = last_blk_r ? B_OUT : B_IDLE;
      B_OUT:  if (out_ch.ready && (idx_r == DIGEST_LAST_IDX)) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      t_r     <= 7'd0;
      idx_r   <= 3'd0;
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= init_chain(3'(i));
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        B_IDLE: t_r <= 7'd0;
        B_RND:  if (rnd_go) t_r <= t_r + 7'd1;
        B_ADD: begin
          idx_r <= 3'd0;
          for (int i = 0; i < 5; i++) begin
            chain_r[i] <= chain_r[i] + rr_r[i];
          end
        end
        B_OUT: begin
          if (out_ch.ready) begin
            idx_r <= idx_r + 3'd1;
            // The chain returns to its initial value once the digest is out.
            if (idx_r == DIGEST_LAST_IDX) begin
              for (int i = 0; i < 5; i++) begin
                chain_r[i] <= init_chain(3'(i));
              end
            end
          end
        end
        default: t_r <= 7'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE) begin
      for (int i = 0; i < 5; i++) begin
        rr_r[i] <= chain_r[i];
      end
    end else if (rnd_go) begin
      rr_r[0] <= tmp;
      rr_r[1] <= rr_r[0];
      rr_r[2] <= rotl30(rr_r[1]);
      rr_r[3] <= rr_r[2];
      rr_r[4] <= rr_r[3];
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w;
      if (t_r == {3'd0, BLK_LAST_IDX}) begin
        last_blk_r <= q_rdata.msg_end;
      end
    end
  end

  assign out_ch.valid       = (state_r == B_OUT);
  assign out_ch.digest_word = chain_r[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == DIGEST_LAST_IDX);

endmodule

[hdl/sha1_message_digest_core.sv]
// Bytes are taken one per cycle while the four-word queue has room and no padding is pending.
// Each block passes through a load, 80 rounds and a chaining add in the engine, while the front
// keeps filling the queue with the next words until it is full.
// A final item adds 3 to 18 padding words, which may spill the length into a block of its own;
// the digest words then leave one per cycle while the receiver is ready.
// Synchronous active-low reset restores the initial chain, a zero length and an empty queue.
module sha1_message_digest_core
  import sha1md_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  sha1md_in_if.sink     in_ch,
  sha1md_out_if.source  out_ch
);

  qctl_t  qctl;
  qword_t q_wdata;
  qword_t q_rdata;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  sha1md_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .qctl    (qctl),
    .q_full  (q_full),
    .q_wdata (q_wdata)
  );

  sha1md_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .qctl   (qctl),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  sha1md_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[hdl/sha1md_checker.sv]
module sha1md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_final,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [2:0]  out_index,
  input logic        out_last
);

  logic [2:0] exp_idx_r;
  logic [2:0] pend_r;
  logic       in_fin_fire;
  logic       out_end_fire;

  assign in_fin_fire  = in_valid && in_ready && in_final;
  assign out_end_fire = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= 3'd0;
      pend_r    <= 3'd0;
    end else begin
      if (out_valid && out_ready) begin
        exp_idx_r <= out_last ? 3'd0 : exp_idx_r + 3'd1;
      end
      case ({in_fin_fire, out_end_fire})
        2'b10:   pend_r <= pend_r + 3'd1;
        2'b01:   pend_r <= pend_r - 3'd1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_index))
    else $error("digest word changed while stalled");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_index == exp_idx_r)
    else $error("digest words out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last == (out_index == 3'd4))
    else $error("last word flag on the wrong word");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 3'd0) || (exp_idx_r != 3'd0))
    else $error("digest without a finished message");

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.final_item),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.digest_word),
  .out_index (out_ch.word_index),
  .out_last  (out_ch.last_word)
);

[tb/sv/sha1_digest_checker.sv]
`timescale 1ns / 100ps

module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  sha1md_in_if        in_mon,
  sha1md_out_if       out_mon,
  output int unsigned fail_count,
  output int unsigned pending_words
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_entry_t;

  localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};
  localparam logic [7:0]   PAD_BYTE = 8'h80;

  logic [159:0]  chain_state;
  logic [511:0]  block_bytes;
  logic [63:0]   bit_count;
  int unsigned   fill_pos;
  digest_entry_t expected_digest [$];
  digest_entry_t got;
  digest_entry_t want;

  function automatic logic [31:0] rot_left(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One 80-round compression of a 64-byte block onto the chaining value.
  function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                 input logic [511:0] blk);
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, w, t;
    for (int r = 0; r < 16; r++) begin
      sched[r] = blk[511 - 32 * r -: 32];
    end
    a = h[159:128];
    b = h[127:96];
    c = h[95:64];
    d = h[63:32];
    e = h[31:0];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = rot_left(sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^
                     sched[(r - 14) & 15] ^ sched[r & 15], 1);
        sched[r & 15] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rot_left(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rot_left(b, 30);
      b = a;
      a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chain_state = SHA1_IV;
      block_bytes = '0;
      bit_count = '0;
      expected_digest.delete();
      fail_count = 0;
      pending_words = 0;
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        if (in_mon.byte_present === 1'b1) begin
          fill_pos = bit_count[8:3];
          block_bytes[511 - 8 * fill_pos -: 8] = in_mon.data_byte;
          bit_count = bit_count + 64'd8;
          if (fill_pos == 63) begin
            chain_state = sha1_compress(chain_state, block_bytes);
          end
        end
        if (in_mon.final_item === 1'b1) begin
          // The marker byte, zeros, and the bit length in the last eight bytes;
          // a marker past byte 55 leaves no room, so the length gets a block of its own.
          fill_pos = bit_count[8:3];
          block_bytes[511 - 8 * fill_pos -: 8] = PAD_BYTE;
          for (int unsigned i = fill_pos + 1; i < 64; i++) begin
            block_bytes[511 - 8 * i -: 8] = 8'h00;
          end
          if (fill_pos >= 56) begin
            chain_state = sha1_compress(chain_state, block_bytes);
            block_bytes = '0;
          end
          block_bytes[63:0] = bit_count;
          chain_state = sha1_compress(chain_state, block_bytes);
          for (int unsigned i = 0; i < 5; i++) begin
            expected_digest.push_back('{digest_word: chain_state[159 - 32 * i -: 32],
                                        word_index: 3'(i),
                                        last_word: (i == 4)});
          end
          chain_state = SHA1_IV;
          bit_count = '0;
        end
      end

      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{digest_word: out_mon.digest_word, word_index: out_mon.word_index,
                last_word: out_mon.last_word};
        if (expected_digest.size() == 0) begin
          $error("unexpected digest word %h (index %0d) with nothing outstanding",
                 got.digest_word, got.word_index);
          fail_count++;
        end else begin
          want = expected_digest.pop_front();
          if (got.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
            fail_count++;
          end
          if (got.word_index !== want.word_index) begin
            $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
            fail_count++;
          end
          if (got.last_word !== want.last_word) begin
            $error("last_word: expected %b, actual %b", want.last_word, got.last_word);
            fail_count++;
          end
        end
      end
      pending_words = expected_digest.size();
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS    = 12;
  localparam int unsigned PHASE_MSGS     = 2;

  logic        clk;
  logic        rst_n;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_req;
  int unsigned data_items;
  int unsigned fail_count;
  int unsigned pending_words;

  sha1md_in_if  in_ch ();
  sha1md_out_if out_ch ();

  sha1_message_digest_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha1_digest_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one word and returns at the edge where it is taken.
  task automatic offer_item(input logic [7:0] b, input logic present, input logic fin);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.data_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.byte_present <= present;
    in_ch.final_item <= fin;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (present || fin) data_items++;
  endtask

  // Random bytes with the odd ignored word mixed in; the end flag rides on the
  // last byte or comes alone.
  task automatic send_message(input int unsigned len);
    bit merge;
    merge = (len != 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) offer_item(8'($urandom_range(255)), 1'b0, 1'b0);
      offer_item(8'($urandom_range(255)), 1'b1, merge && (i == len - 1));
    end
    if (!merge) offer_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Mostly short messages, some near the point where padding spills into a
  // second block, and a few near the same point one block later.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(8);
    if (r < 97) return $urandom_range(66, 52);
    return $urandom_range(130, 118);
  endfunction

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    int unsigned start_items;
    int unsigned msgs;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_items = data_items;
    msgs = 0;
    while (data_items - start_items < PHASE_ITEMS || msgs < PHASE_MSGS) begin
      send_message(pick_len());
      msgs++;
    end
    drain_results();
  endtask

  // Result side: random stalls, plus a long hold whenever one is requested.
  initial begin
    int unsigned holds_seen;
    int unsigned hold_left;
    holds_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req != holds_seen) begin
        holds_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    data_items = 0;
    hold_req <= 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.byte_present <= 1'b0;
    in_ch.final_item <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message: a lone end flag with no byte.
    offer_item(8'h00, 1'b0, 1'b1);
    // "abc" with an ignored word inside and the end flag on the last byte.
    offer_item(8'h61, 1'b1, 1'b0);
    offer_item(8'hFF, 1'b0, 1'b0);
    offer_item(8'h62, 1'b1, 1'b0);
    offer_item(8'h63, 1'b1, 1'b1);
    // Byte extremes, then an end flag that carries no byte.
    offer_item(8'h00, 1'b1, 1'b0);
    offer_item(8'hFF, 1'b1, 1'b0);
    offer_item(8'h3C, 1'b0, 1'b1);
    offer_item(8'hFF, 1'b1, 1'b1);
    // Data on an ignored word must not leak into the next digest.
    offer_item(8'hA5, 1'b0, 1'b0);
    offer_item(8'h5A, 1'b0, 1'b1);
    drain_results();

    run_phase(25, 63);
    run_phase(63, 25);

    // Hold the result side while three messages go in, so the block backs up.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= hold_req + 1;
    send_message(20);
    send_message(8);
    send_message(4);
    drain_results();

    run_phase(0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/sha1md_pkg.sv
hdl/sha1md_if.sv
hdl/sha1md_front.sv
hdl/sha1md_queue.sv
hdl/sha1md_back.sv
hdl/sha1_message_digest_core.sv
hdl/sha1md_checker.sv
tb/sv/sha1_digest_checker.sv
tb/sv/tb.sv
